[rtl/calendar_date_unit_core_defines.svh]
// Assertion macros shared by the calendar date unit. The including scope
// provides clk and rst.
`ifndef CALENDAR_DATE_UNIT_CORE_DEFINES_SVH
`define CALENDAR_DATE_UNIT_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define CDU_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
`define CDU_ASSERT_IMPL(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error("implication failed");
`else
`define CDU_ASSERT(lbl, prop)
`define CDU_ASSERT_IMPL(lbl, pre, post)
`endif
`endif

[rtl/cdu_pkg.sv]
`timescale 1ns / 1ps
package cdu_pkg;

  localparam int NSTG = 8;

  // Serial offset so that 1969-01-01 maps to zero.
  localparam logic [16:0] YEAR_BIAS = 17'd364;
  localparam logic [16:0] LAST_POS  = 17'd65899;
  localparam logic [7:0]  LAST_YIDX = 8'd180;
  localparam logic [7:0]  Y2100_IDX = 8'd131;

  typedef logic [NSTG:1] cdu_adv_t;

  typedef struct packed {
    logic [7:0]  yidx;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  mlen;
    logic        leap;
    logic [16:0] ystart;
    logic [2:0]  wd;
  } cdu_ymd_t;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [2:0]  wd;
    logic [4:0]  mlen;
    logic [15:0] mes;
    logic [15:0] res;
  } cdu_shres_t;

  // Days from 1969-01-01 to January 1 of year 1969 + i.
  function automatic logic [16:0] year_start(input logic [7:0] i);
    logic [11:0] y1;
    logic [9:0]  leaps;
    y1 = 12'(i) + 12'd1968;
    leaps = 10'(y1 >> 2) - 10'd492 - ((i > Y2100_IDX) ? 10'd1 : 10'd0);
    return 17'(i) * 17'd365 + 17'(leaps);
  endfunction

  function automatic logic year_leap(input logic [7:0] i);
    logic [7:0] n;
    n = i + 8'd1;
    return (n[1:0] == 2'd0) && (i != Y2100_IDX);
  endfunction

  function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
    logic [8:0] s;
    case (m)
      4'd1:    s = 9'd0;
      4'd2:    s = 9'd31;
      4'd3:    s = 9'd59;
      4'd4:    s = 9'd90;
      4'd5:    s = 9'd120;
      4'd6:    s = 9'd151;
      4'd7:    s = 9'd181;
      4'd8:    s = 9'd212;
      4'd9:    s = 9'd243;
      4'd10:   s = 9'd273;
      4'd11:   s = 9'd304;
      4'd12:   s = 9'd334;
      default: s = 9'd0;
    endcase
    if (m > 4'd2 && leap) begin
      s = s + 9'd1;
    end
    return s;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] l;
    case (m)
      4'd2:                      l = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   l = 5'd30;
      default:                   l = 5'd31;
    endcase
    return l;
  endfunction

  function automatic logic [2:0] mod7(input logic [16:0] x);
    logic [5:0] s;
    logic [3:0] s2;
    s = 6'(x[2:0]) + 6'(x[5:3]) + 6'(x[8:6]) + 6'(x[11:9]) + 6'(x[14:12]) + 6'(x[16:15]);
    s2 = 4'(s[2:0]) + 4'(s[5:3]);
    return (s2 >= 4'd7) ? 3'(s2 - 4'd7) : s2[2:0];
  endfunction

  // floor(367 * (m - 2 - 12a) / 12) of the integer date formula.
  function automatic logic [8:0] enc_month_term(input logic [3:0] m);
    logic [8:0] t;
    case (m)
      4'd0:    t = 9'd305;
      4'd1:    t = 9'd336;
      4'd2:    t = 9'd367;
      4'd3:    t = 9'd30;
      4'd4:    t = 9'd61;
      4'd5:    t = 9'd91;
      4'd6:    t = 9'd122;
      4'd7:    t = 9'd152;
      4'd8:    t = 9'd183;
      4'd9:    t = 9'd214;
      4'd10:   t = 9'd244;
      4'd11:   t = 9'd275;
      4'd12:   t = 9'd305;
      4'd13:   t = 9'd336;
      4'd14:   t = 9'd367;
      default: t = 9'd397;
    endcase
    return t;
  endfunction

endpackage

[rtl/cdu_in_if.sv]
`timescale 1ns / 1ps
interface cdu_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [15:0] date_serial;
  logic [11:0] month_shift;
  logic        keep_end_of_month;
  logic [11:0] year_in;
  logic [3:0]  month_in;
  logic [4:0]  day_in;

  modport source (output valid, action, date_serial, month_shift, keep_end_of_month,
                  year_in, month_in, day_in, input ready);
  modport sink (input valid, action, date_serial, month_shift, keep_end_of_month,
                year_in, month_in, day_in, output ready);
endinterface

[rtl/cdu_out_if.sv]
`timescale 1ns / 1ps
interface cdu_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] year_out;
  logic [3:0]  month_out;
  logic [4:0]  day_out;
  logic [2:0]  weekday;
  logic [4:0]  month_length;
  logic [15:0] month_end_serial;
  logic [15:0] result_serial;
  logic        valid_res;

  modport source (output valid, year_out, month_out, day_out, weekday, month_length,
                  month_end_serial, result_serial, valid_res, input ready);
  modport sink (input valid, year_out, month_out, day_out, weekday, month_length,
                month_end_serial, result_serial, valid_res, output ready);
endinterface

[rtl/cdu_decode.sv]
`timescale 1ns / 1ps
module cdu_decode import cdu_pkg::*; (
  input  logic        clk,
  input  cdu_adv_t    adv,
  input  logic [15:0] date_serial,
  output cdu_ymd_t    ymd
);

  logic [16:0] s1_pos;
  logic [7:0]  s1_est;
  logic [2:0]  s1_wd;
  logic [34:0] est_prod;
  logic [16:0] pos_in;

  logic [7:0]  s2_yidx;
  logic [8:0]  s2_doy;
  logic        s2_leap;
  logic [16:0] s2_ys;
  logic [2:0]  s2_wd;
  logic [16:0] ys_lo;
  logic [16:0] ys_hi;
  logic        take_hi;
  logic [7:0]  yidx_sel;
  logic [16:0] ys_sel;

  logic [3:0]  mon;
  logic [8:0]  doy_left;

  assign pos_in   = 17'(date_serial) + YEAR_BIAS;
  assign est_prod = 35'(pos_in) * 35'd183358;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s1_pos <= pos_in;
      s1_est <= est_prod[33:26];
      s1_wd  <= mod7(17'(date_serial) + 17'd24594);
    end
  end

  assign ys_lo    = year_start(s1_est);
  assign ys_hi    = year_start(s1_est + 8'd1);
  assign take_hi  = (ys_hi <= s1_pos);
  assign yidx_sel = take_hi ? s1_est + 8'd1 : s1_est;
  assign ys_sel   = take_hi ? ys_hi : ys_lo;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s2_yidx <= yidx_sel;
      s2_doy  <= 9'(s1_pos - ys_sel);
      s2_leap <= year_leap(yidx_sel);
      s2_ys   <= ys_sel;
      s2_wd   <= s1_wd;
    end
  end

  always_comb begin
    mon = 4'd1;
    for (int k = 2; k <= 12; k++) begin
      if (s2_doy >= month_start(4'(k), s2_leap)) begin
        mon = mon + 4'd1;
      end
    end
    doy_left = s2_doy - month_start(mon, s2_leap) + 9'd1;
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      ymd.yidx   <= s2_yidx;
      ymd.month  <= mon;
      ymd.day    <= doy_left[4:0];
      ymd.mlen   <= month_len(mon, s2_leap);
      ymd.leap   <= s2_leap;
      ymd.ystart <= s2_ys;
      ymd.wd     <= s2_wd;
    end
  end

endmodule

[rtl/cdu_encode.sv]
`timescale 1ns / 1ps
module cdu_encode import cdu_pkg::*; (
  input  logic        clk,
  input  cdu_adv_t    adv,
  input  logic [11:0] year_in,
  input  logic [3:0]  month_in,
  input  logic [4:0]  day_in,
  output logic [15:0] enc_serial
);

  logic               a_neg;
  logic signed [12:0] s1_ya;
  logic [13:0]        s1_n;
  logic [8:0]         s1_t2;
  logic [4:0]         s1_d;

  logic [23:0]        t1_prod;
  logic [26:0]        c_prod;
  logic signed [22:0] s2_t1;
  logic [6:0]         s2_c;
  logic [8:0]         s2_t2;
  logic [4:0]         s2_d;

  logic [8:0]         c3;
  logic signed [24:0] day_num;

  assign a_neg = (month_in <= 4'd2);

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s1_ya <= $signed({1'b0, year_in}) - (a_neg ? 13'sd1 : 13'sd0);
      s1_n  <= 14'(year_in) + 14'd4900 - (a_neg ? 14'd1 : 14'd0);
      s1_t2 <= enc_month_term(month_in);
      s1_d  <= day_in;
    end
  end

  assign t1_prod = 24'(s1_ya[11:0]) * 24'd1461;
  assign c_prod  = 27'(s1_n) * 27'd10486;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s2_t1 <= s1_ya[12] ? -23'sd365 : $signed({1'b0, t1_prod[23:2]});
      s2_c  <= c_prod[26:20];
      s2_t2 <= s1_t2;
      s2_d  <= s1_d;
    end
  end

  assign c3 = 9'(s2_c) * 9'd3;
  assign day_num = 25'(s2_t1) + $signed(25'(s2_t2)) - $signed(25'(c3[8:2]))
                 + $signed(25'(s2_d)) - 25'sd719462;

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      enc_serial <= (day_num >= 25'sd0 && day_num <= 25'sd65535) ? day_num[15:0] : 16'd0;
    end
  end

endmodule

[rtl/cdu_shift.sv]
`timescale 1ns / 1ps
module cdu_shift import cdu_pkg::*; (
  input  logic        clk,
  input  cdu_adv_t    adv,
  input  cdu_ymd_t    ymd,
  input  logic [11:0] month_shift,
  input  logic        keep_end_of_month,
  output cdu_shres_t  sres
);

  logic [16:0] pend;
  logic [13:0] u_full;

  logic [12:0] s4_u;
  logic [15:0] s4_mes;
  logic        s4_to_end;
  logic [11:0] s4_year;
  logic [3:0]  s4_month;
  logic [4:0]  s4_day;
  logic [2:0]  s4_wd;
  logic [4:0]  s4_mlen;

  logic [25:0] q_prod;
  logic [12:0] s5_u;
  logic [9:0]  s5_q;
  logic [15:0] s5_mes;
  logic        s5_to_end;
  logic [11:0] s5_year;
  logic [3:0]  s5_month;
  logic [4:0]  s5_day;
  logic [2:0]  s5_wd;
  logic [4:0]  s5_mlen;

  logic [12:0]        mm_full;
  logic [3:0]         nm;
  logic signed [10:0] ni;
  logic               ni_ok;
  logic               nleap;
  logic [4:0]         dmax;
  logic [16:0] s6_ys;
  logic [8:0]  s6_cum;
  logic [4:0]  s6_d;
  logic        s6_ok;
  logic [15:0] s6_mes;
  logic [11:0] s6_year;
  logic [3:0]  s6_month;
  logic [4:0]  s6_day;
  logic [2:0]  s6_wd;
  logic [4:0]  s6_mlen;

  logic [16:0] npos;

  assign pend = ymd.ystart + 17'(month_start(ymd.month, ymd.leap)) + 17'(ymd.mlen) - 17'd1;
  assign u_full = 14'(ymd.yidx) * 14'd12 + 14'(ymd.month) - 14'd1 + 14'd2052
                + {{2{month_shift[11]}}, month_shift};

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      s4_u      <= u_full[12:0];
      s4_mes    <= (pend >= YEAR_BIAS && pend <= LAST_POS) ? 16'(pend - YEAR_BIAS) : 16'd0;
      s4_to_end <= keep_end_of_month && (ymd.day == ymd.mlen);
      s4_year   <= 12'(ymd.yidx) + 12'd1969;
      s4_month  <= ymd.month;
      s4_day    <= ymd.day;
      s4_wd     <= ymd.wd;
      s4_mlen   <= ymd.mlen;
    end
  end

  assign q_prod = 26'(s4_u) * 26'd5462;

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      s5_u      <= s4_u;
      s5_q      <= q_prod[25:16];
      s5_mes    <= s4_mes;
      s5_to_end <= s4_to_end;
      s5_year   <= s4_year;
      s5_month  <= s4_month;
      s5_day    <= s4_day;
      s5_wd     <= s4_wd;
      s5_mlen   <= s4_mlen;
    end
  end

  assign mm_full = s5_u - 13'(s5_q) * 13'd12;
  assign nm      = mm_full[3:0] + 4'd1;
  assign ni      = $signed({1'b0, s5_q}) - 11'sd171;
  assign ni_ok   = (ni >= 11'sd0) && (ni <= $signed({3'b0, LAST_YIDX}));
  assign nleap   = year_leap(ni[7:0]);
  assign dmax    = month_len(nm, nleap);

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      s6_ys    <= year_start(ni[7:0]);
      s6_cum   <= month_start(nm, nleap);
      s6_d     <= (s5_to_end || s5_day > dmax) ? dmax : s5_day;
      s6_ok    <= ni_ok;
      s6_mes   <= s5_mes;
      s6_year  <= s5_year;
      s6_month <= s5_month;
      s6_day   <= s5_day;
      s6_wd    <= s5_wd;
      s6_mlen  <= s5_mlen;
    end
  end

  assign npos = s6_ys + 17'(s6_cum) + 17'(s6_d) - 17'd1;

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      sres.res   <= (s6_ok && npos >= YEAR_BIAS && npos <= LAST_POS) ?
                    16'(npos - YEAR_BIAS) : 16'd0;
      sres.mes   <= s6_mes;
      sres.year  <= s6_year;
      sres.month <= s6_month;
      sres.day   <= s6_day;
      sres.wd    <= s6_wd;
      sres.mlen  <= s6_mlen;
    end
  end

endmodule

[rtl/calendar_date_unit_core.sv]
// Calendar date unit: one transaction per clock in and out while the response is not
// stalled, through eight register stages (year estimate, year correction, month search,
// month shift setup, month quotient multiply, target month lookup, target serial sum,
// output register). Action 0 decodes a day serial (1 is 1970-01-01) and shifts it by a
// signed month count; action 1 encodes year, month and day. A stalled response holds
// each full stage behind it, while empty stages still fill; nothing is lost or repeated.
`timescale 1ns / 1ps
`include "calendar_date_unit_core_defines.svh"
module calendar_date_unit_core import cdu_pkg::*; (
  input logic      clk,
  input logic      rst,
  cdu_in_if.sink   req,
  cdu_out_if.source rsp
);

  cdu_adv_t    adv;
  logic [NSTG:1] vld;
  logic [NSTG:1] vld_next;

  logic        act_q  [1:NSTG-1];
  logic        snz_q  [1:NSTG-1];
  logic [11:0] sh_q   [1:3];
  logic        keep_q [1:3];
  logic [15:0] enc_q  [4:NSTG-1];

  cdu_ymd_t    ymd;
  cdu_shres_t  sres;
  logic [15:0] enc_serial;

  always_comb begin
    adv[NSTG] = !vld[NSTG] || rsp.ready;
    for (int k = NSTG - 1; k >= 1; k--) begin
      adv[k] = !vld[k] || adv[k + 1];
    end
    vld_next = vld;
    if (adv[1]) begin
      vld_next[1] = req.valid;
    end
    for (int k = 2; k <= NSTG; k++) begin
      if (adv[k]) begin
        vld_next[k] = vld[k - 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= vld_next;
    end
  end

  assign req.ready = adv[1];

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      act_q[1]  <= req.action;
      snz_q[1]  <= (req.date_serial != 16'd0);
      sh_q[1]   <= req.month_shift;
      keep_q[1] <= req.keep_end_of_month;
    end
    for (int k = 2; k <= 3; k++) begin
      if (adv[k]) begin
        sh_q[k]   <= sh_q[k - 1];
        keep_q[k] <= keep_q[k - 1];
      end
    end
    for (int k = 2; k <= NSTG - 1; k++) begin
      if (adv[k]) begin
        act_q[k] <= act_q[k - 1];
        snz_q[k] <= snz_q[k - 1];
      end
    end
    if (adv[4]) begin
      enc_q[4] <= enc_serial;
    end
    for (int k = 5; k <= NSTG - 1; k++) begin
      if (adv[k]) begin
        enc_q[k] <= enc_q[k - 1];
      end
    end
  end

  cdu_decode u_decode (
    .clk         (clk),
    .adv         (adv),
    .date_serial (req.date_serial),
    .ymd         (ymd)
  );

  cdu_encode u_encode (
    .clk        (clk),
    .adv        (adv),
    .year_in    (req.year_in),
    .month_in   (req.month_in),
    .day_in     (req.day_in),
    .enc_serial (enc_serial)
  );

  cdu_shift u_shift (
    .clk               (clk),
    .adv               (adv),
    .ymd               (ymd),
    .month_shift       (sh_q[3]),
    .keep_end_of_month (keep_q[3]),
    .sres              (sres)
  );

  always_ff @(posedge clk) begin
    if (adv[NSTG]) begin
      if (act_q[NSTG - 1]) begin
        rsp.year_out         <= 12'd0;
        rsp.month_out        <= 4'd0;
        rsp.day_out          <= 5'd0;
        rsp.weekday          <= 3'd0;
        rsp.month_length     <= 5'd0;
        rsp.month_end_serial <= 16'd0;
        rsp.result_serial    <= enc_q[NSTG - 1];
        rsp.valid_res        <= (enc_q[NSTG - 1] != 16'd0);
      end else begin
        rsp.year_out         <= sres.year;
        rsp.month_out        <= sres.month;
        rsp.day_out          <= sres.day;
        rsp.weekday          <= sres.wd;
        rsp.month_length     <= sres.mlen;
        rsp.month_end_serial <= sres.mes;
        rsp.result_serial    <= sres.res;
        rsp.valid_res        <= snz_q[NSTG - 1] && (sres.res != 16'd0);
      end
    end
  end

  assign rsp.valid = vld[NSTG];

  `CDU_ASSERT_IMPL(a_res_nonzero, rsp.valid && rsp.valid_res, rsp.result_serial != 16'd0)
  `CDU_ASSERT_IMPL(a_day_fits, rsp.valid && rsp.month_out != 4'd0, rsp.day_out <= rsp.month_length && rsp.month_length >= 5'd28)
  `CDU_ASSERT_IMPL(a_enc_zero, rsp.valid && rsp.month_out == 4'd0, rsp.weekday == 3'd0 && rsp.month_end_serial == 16'd0)

endmodule
